@@ hdl/rea_pkg.sv @@
// Shared types, constants and controller codes for the reprojection error accumulator.
`timescale 1ns / 1ps
package rea_pkg;
  localparam int FRAC_BITS = 16;
  localparam int MAX_FRAME_POINTS = 65536;
  localparam int CNT_W = $clog2(MAX_FRAME_POINTS + 1);
  localparam int NUM_REGS = 6;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W = 64;
  localparam logic [47:0] SUM48_MAX = '1;
  localparam logic [31:0] W32_MAX = '1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_POINTS);

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] point_w;
    logic signed [31:0] obs_u;
    logic signed [31:0] obs_v;
    logic               last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic [31:0] point_error;
    logic        depth_zero;
    logic        frame_done;
    logic [47:0] frame_sum;
    logic [31:0] frame_average;
    logic [63:0] total_error;
    logic [31:0] frames_seen;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_CHECK, ST_DIV_U, ST_DIV_V, ST_SQ, ST_SQRT,
    ST_ACC, ST_AVG, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mac_step;
    logic div_start;
    logic div_sel_v;
    logic div_step;
    logic div_take;
    logic sq_step;
    logic sqrt_start;
    logic sqrt_step;
    logic acc;
    logic avg_start;
    logic avg_step;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mac_done;
    logic depth_zero;
    logic div_done;
    logic sqrt_done;
    logic avg_done;
    logic last;
  } dp_status_t;
endpackage

@@ hdl/rea_stream_if.sv @@
// Valid/ready stream interface carrying one payload.
`timescale 1ns / 1ps
interface rea_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/rea_ctrl.sv @@
// Controller state machine sequencing the datapath for one item.
`timescale 1ns / 1ps
module rea_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rea_pkg::dp_status_t status,
  output rea_pkg::dp_cmd_t    cmd
);
  import rea_pkg::*;

  state_t state, state_next;
  logic   out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MAC;
      ST_MAC:   if (status.mac_done) state_next = ST_CHECK;
      ST_CHECK: state_next = status.depth_zero ? ST_ACC : ST_DIV_U;
      ST_DIV_U: if (status.div_done) state_next = ST_DIV_V;
      ST_DIV_V: if (status.div_done) state_next = ST_SQ;
      ST_SQ:    state_next = ST_SQRT;
      ST_SQRT:  if (status.sqrt_done) state_next = ST_ACC;
      ST_ACC:   state_next = status.last ? ST_AVG : ST_OUT;
      ST_AVG:   if (status.avg_done) state_next = ST_OUT;
      ST_OUT:   if (!out_full || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE);
    out_valid = out_full;
    out_full_next = out_full && !out_ready;
    unique case (state)
      ST_IDLE:  cmd.load = in_valid;
      ST_MAC:   cmd.mac_step = 1'b1;
      ST_CHECK: cmd.div_start = !status.depth_zero;
      ST_DIV_U: begin
        cmd.div_step = !status.div_done;
        if (status.div_done) begin
          cmd.div_take  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_v = 1'b1;
        end
      end
      ST_DIV_V: begin
        cmd.div_sel_v = 1'b1;
        cmd.div_step  = !status.div_done;
        cmd.div_take  = status.div_done;
      end
      ST_SQ:    begin cmd.sq_step = 1'b1; cmd.sqrt_start = 1'b1; end
      ST_SQRT:  cmd.sqrt_step = !status.sqrt_done;
      ST_ACC:   begin cmd.acc = 1'b1; cmd.avg_start = status.last; end
      ST_AVG:   cmd.avg_step = 1'b1;
      ST_OUT: begin
        if (!out_full || out_ready) begin
          cmd.out_load  = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ hdl/rea_datapath.sv @@
// Datapath: matrix MAC, shared divider, square root, accumulators, output register.
`timescale 1ns / 1ps
module rea_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [63:0]             cfg_data,
  input  rea_pkg::in_item_t       in_item,
  input  rea_pkg::dp_cmd_t        cmd,
  output rea_pkg::dp_status_t     status,
  output rea_pkg::out_item_t      out_item
);
  import rea_pkg::*;

  logic [63:0] cam [NUM_REGS];
  in_item_t    item;

  // MAC: 12 products, one per cycle
  logic [3:0]          mac_cnt;
  logic [1:0]          mac_row, mac_col;
  logic signed [31:0]  m_coef, m_pt;
  logic signed [63:0]  prod;
  logic signed [63:0]  p0, p1, p2;
  logic                prod_vld;
  logic [1:0]          prod_row;
  logic [63:0]         creg;

  // divider
  logic [63:0] dn, dd, dr, dq;
  logic        dneg, ddone;
  logic [6:0]  dcnt;
  logic [63:0] du_mag, dv_mag;
  logic        far;

  // square root
  logic [63:0] sx, sres, sbit, ssum;
  logic        sdone;
  logic [5:0]  scnt;
  logic [31:0] err;

  // accumulators
  logic [47:0]      fsum;
  logic [CNT_W-1:0] fcnt;
  logic [63:0]      tot;
  logic [31:0]      fctr;
  logic [47:0]      fsum_new;
  logic [63:0]      tot_new;
  logic [48:0]      fs_add;
  logic [64:0]      tt_add;

  // average divider: 48-bit restoring, one bit per cycle
  logic [47:0]      aq;
  logic [CNT_W:0]   ar;
  logic [5:0]       acnt;
  logic [31:0]      avg;
  logic             avg_done;
  logic [47:0]      fsum_out;

  always_ff @(posedge clk) begin
    if (cfg_we && cfg_index < REG_IDX_W'(NUM_REGS)) cam[cfg_index] <= cfg_data;
    if (rst) for (int i = 0; i < NUM_REGS; i++) cam[i] <= '0;
  end

  assign mac_row = mac_cnt[3:2];
  assign mac_col = mac_cnt[1:0];
  always_comb begin
    creg = cam[{mac_row, mac_col[1]}];
    m_coef = mac_col[0] ? creg[63:32] : creg[31:0];
    unique case (mac_col)
      2'd0: m_pt = item.point_x;
      2'd1: m_pt = item.point_y;
      2'd2: m_pt = item.point_z;
      default: m_pt = item.point_w;
    endcase
  end

  assign status.mac_done = !prod_vld && mac_cnt == 4'd12;
  assign status.depth_zero = (p2 == 0);
  assign status.last = item.last_in_frame;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      mac_cnt <= '0;
      prod_vld <= 1'b0;
      p0 <= '0; p1 <= '0; p2 <= '0;
    end else if (cmd.mac_step) begin
      if (mac_cnt != 4'd12) begin
        prod <= m_coef * m_pt;
        prod_row <= mac_row;
        mac_cnt <= mac_cnt + 4'd1;
      end
      prod_vld <= mac_cnt != 4'd12;
      if (prod_vld) begin
        unique case (prod_row)
          2'd0: p0 <= p0 + (prod >>> FRAC_BITS);
          2'd1: p1 <= p1 + (prod >>> FRAC_BITS);
          default: p2 <= p2 + (prod >>> FRAC_BITS);
        endcase
      end
    end
  end

  // restoring division of |num|<<F by |p2|; quotient cap checked on integer part
  logic [63:0] num_sel;
  logic [63:0] dr_sh;
  logic signed [63:0] obs_sel, diff;
  logic [63:0] q_fin;
  assign num_sel = cmd.div_sel_v ? p1 : p0;
  assign status.div_done = ddone;
  always_comb begin
    dr_sh = {dr[62:0], dn[63]};
    q_fin = dq;
    if (dq >= (64'd1 << (40 - FRAC_BITS)) << FRAC_BITS) q_fin = 64'd1 << 40;
    // the u quotient is taken in the cycle that restarts the divider for v
    obs_sel = (cmd.div_sel_v && !cmd.div_start) ? 64'(item.obs_v) : 64'(item.obs_u);
    diff = (dneg ? -$signed(q_fin) : $signed(q_fin)) - obs_sel;
  end
  // integer part first (64 steps), then FRAC_BITS fraction steps
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dn <= num_sel[63] ? -num_sel : num_sel;
      dd <= p2[63] ? -p2 : p2;
      dneg <= num_sel[63] ^ p2[63];
      dr <= '0; dq <= '0; dcnt <= '0; ddone <= 1'b0;
    end else if (cmd.div_step) begin
      dn <= {dn[62:0], 1'b0};
      if (dr_sh >= dd) begin
        dr <= dr_sh - dd; dq <= {dq[62:0], 1'b1};
      end else begin
        dr <= dr_sh; dq <= {dq[62:0], 1'b0};
      end
      // count the step; done is set after the last fraction step
      dcnt <= dcnt + 7'd1;
      if (dcnt == 7'(64 + FRAC_BITS - 1)) ddone <= 1'b1;
    end
    if (cmd.div_take) begin
      if (cmd.div_sel_v && !cmd.div_start) dv_mag <= diff[63] ? -diff : diff;
      else du_mag <= diff[63] ? -diff : diff;
    end
  end
  // saturating quotient: dq keeps only 64 bits, so a quotient of 2^64 or more loses its top
  // bits during the shift and the q_fin cap does not catch it.

  // squared distance and square root
  logic [63:0] a_sq, b_sq;
  logic [64:0] ab;
  logic        sat_sq;
  always_comb begin
    ssum = sres + sbit;
    ab = {1'b0, a_sq} + {1'b0, b_sq};
  end
  assign status.sqrt_done = sdone;
  always_ff @(posedge clk) begin
    if (cmd.sq_step) begin
      a_sq <= du_mag[31:0] * du_mag[31:0];
      b_sq <= dv_mag[31:0] * dv_mag[31:0];
      far  <= du_mag[63:32] != 0 || dv_mag[63:32] != 0;
    end
    if (cmd.sqrt_start) begin
      sres <= '0; sbit <= 64'd1 << 62; scnt <= '0; sdone <= 1'b0; sat_sq <= 1'b0;
    end else if (cmd.sqrt_step) begin
      if (scnt == 6'd0) begin
        sx <= ab[63:0];
        sat_sq <= ab[64] | far;
        scnt <= 6'd1;
      end else begin
        if (sx >= ssum) begin
          sx <= sx - ssum; sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
        scnt <= scnt + 6'd1;
        if (scnt == 6'd32) sdone <= 1'b1;
      end
    end
  end

  always_comb begin
    err = '0;
    if (!status.depth_zero) err = sat_sq ? W32_MAX : sres[31:0];
    fs_add = {1'b0, fsum} + 49'(err);
    fsum_new = fs_add[48] ? SUM48_MAX : fs_add[47:0];
    tt_add = {1'b0, tot} + 65'(err);
    tot_new = tt_add[64] ? '1 : tt_add[63:0];
  end

  logic [CNT_W:0] ar_sh;
  logic [CNT_W-1:0] adiv;
  assign ar_sh = {ar[CNT_W-1:0], aq[47]};
  assign status.avg_done = avg_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      fsum <= '0; fcnt <= '0; tot <= '0; fctr <= '0;
    end else if (cmd.acc) begin
      fsum_out <= fsum_new;
      tot <= tot_new;
      if (item.last_in_frame) begin
        fsum <= '0; fcnt <= '0;
        if (fctr != '1) fctr <= fctr + 32'd1;
        adiv <= (fcnt < MAX_CNT) ? fcnt + 1'b1 : fcnt;
      end else begin
        fsum <= fsum_new;
        if (fcnt < MAX_CNT) fcnt <= fcnt + 1'b1;
      end
    end
    if (cmd.avg_start) begin
      aq <= fsum_new; ar <= '0; acnt <= '0; avg_done <= 1'b0;
    end else if (cmd.avg_step && !avg_done) begin
      if (ar_sh >= {1'b0, adiv}) begin
        ar <= ar_sh - {1'b0, adiv}; aq <= {aq[46:0], 1'b1};
      end else begin
        ar <= ar_sh; aq <= {aq[46:0], 1'b0};
      end
      acnt <= acnt + 6'd1;
      if (acnt == 6'd47) avg_done <= 1'b1;
    end
  end
  always_comb avg = (aq[47:32] != 0) ? W32_MAX : aq[31:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.point_error   <= err;
      out_item.depth_zero    <= status.depth_zero;
      out_item.frame_done    <= item.last_in_frame;
      out_item.frame_sum     <= fsum_out;
      out_item.frame_average <= item.last_in_frame ? avg : '0;
      out_item.total_error   <= tot;
      out_item.frames_seen   <= fctr;
    end
  end
endmodule

@@ hdl/reprojection_error_accumulator_top.sv @@
// Top level of the reprojection error accumulator.
// One item at a time: a multiply-accumulate pass for the 3x4 projection, two
// bit-serial perspective divisions in one shared divider, a square root, and on
// a frame's last point an average division; a zero-depth point skips the
// divisions and square root. Results sit in an output register; the next item is
// taken once the result is registered. Camera registers are to be written by the
// user only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
module reprojection_error_accumulator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  rea_stream_if.sink   in_ch,
  rea_stream_if.source out_ch
);
  import rea_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rea_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .cmd(cmd)
  );

  rea_datapath u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in_ch.payload), .cmd(cmd), .status(status),
    .out_item(out_ch.payload)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transfer while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped");
  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.payload.frame_done) |-> out_ch.payload.frame_average == '0)
    else $error("average outside frame end");
endmodule

@@ bench/tb_reprojection_error_accumulator_top.sv @@
// Testbench for the reprojection error accumulator: random and directed points, scoreboard check.
`timescale 1ns / 1ps
module tb_reprojection_error_accumulator_top;
  import rea_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 190;
  localparam logic [2:0] IDX_00_01 = 3'd0;
  localparam logic [2:0] IDX_UNUSED_HI = 3'd7;
  localparam logic [63:0] ONE_Q = 64'h1_0000;

  class error_scoreboard;
    logic [63:0] cam[NUM_REGS];
    logic [47:0] frame_sum;
    logic [16:0] frame_count;
    logic [63:0] run_total;
    logic [31:0] frames_done;
    out_item_t   expected_results[$];
    int          fails;

    function new();
      foreach (cam[i]) cam[i] = '0;
      frame_sum = '0;
      frame_count = '0;
      run_total = '0;
      frames_done = '0;
      fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      if (idx < NUM_REGS) cam[idx] = val;
    endfunction

    function longint coef(int r, int c);
      logic [63:0] w;
      w = cam[r * 2 + c / 2];
      return (c % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
    endfunction

    function void project(in_item_t it, output longint p[3]);
      longint pt[4];
      pt[0] = longint'(it.point_x);
      pt[1] = longint'(it.point_y);
      pt[2] = longint'(it.point_z);
      pt[3] = longint'(it.point_w);
      for (int r = 0; r < 3; r++) begin
        p[r] = 0;
        for (int c = 0; c < 4; c++) p[r] += (coef(r, c) * pt[c]) >>> FRAC_BITS;
      end
    endfunction

    // truncating fixed-point divide, magnitude capped at 2^40
    function longint div_fx(longint num, longint den);
      logic          neg;
      logic [63:0]   n, d, q;
      logic [127:0]  w;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? 64'(-num) : 64'(num);
      d = (den < 0) ? 64'(-den) : 64'(den);
      if (n / d >= (64'd1 << (40 - FRAC_BITS))) q = 64'd1 << 40;
      else begin
        w = {64'd0, n} << FRAC_BITS;
        q = 64'(w / {64'd0, d});
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res, b;
      res = '0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else res = res >> 1;
        b = b >> 2;
      end
      return res;
    endfunction

    function void predict_point(in_item_t it);
      longint      p[3], du, dv;
      logic [63:0] err, a, b, avg;
      logic [64:0] sq, tot;
      out_item_t   o;
      project(it, p);
      err = '0;
      avg = '0;
      if (p[2] != 0) begin
        du = div_fx(p[0], p[2]) - longint'(it.obs_u);
        dv = div_fx(p[1], p[2]) - longint'(it.obs_v);
        if (du < 0) du = -du;
        if (dv < 0) dv = -dv;
        if (du > longint'(W32_MAX) || dv > longint'(W32_MAX)) err = 64'(W32_MAX);
        else begin
          a = 64'(du) * 64'(du);
          b = 64'(dv) * 64'(dv);
          sq = {1'b0, a} + {1'b0, b};
          err = sq[64] ? 64'(W32_MAX) : root_floor(sq[63:0]);
          if (err > 64'(W32_MAX)) err = 64'(W32_MAX);
        end
      end
      frame_sum = (64'(frame_sum) + err > 64'(SUM48_MAX)) ? SUM48_MAX : 48'(frame_sum + err);
      tot = {1'b0, run_total} + {1'b0, err};
      run_total = tot[64] ? '1 : tot[63:0];
      if (frame_count < MAX_FRAME_POINTS) frame_count++;
      o.frame_sum = frame_sum;
      if (it.last_in_frame) begin
        avg = 64'(frame_sum) / 64'(frame_count);
        if (avg > 64'(W32_MAX)) avg = 64'(W32_MAX);
        if (frames_done != '1) frames_done++;
        frame_sum = '0;
        frame_count = '0;
      end
      o.point_error = err[31:0];
      o.depth_zero = (p[2] == 0);
      o.frame_done = it.last_in_frame;
      o.frame_average = avg[31:0];
      o.total_error = run_total;
      o.frames_seen = frames_done;
      expected_results = {expected_results, o};
    endfunction

    function void report(string fld, logic [63:0] e, logic [63:0] a);
      $display("%0t: %s mismatch expected %h actual %h", $time, fld, e, a);
      fails++;
    endfunction

    function void compare_result(out_item_t got);
      out_item_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        fails++;
        return;
      end
      e = expected_results.pop_front();
      if (got.point_error !== e.point_error) report("point_error", e.point_error, got.point_error);
      if (got.depth_zero !== e.depth_zero) report("depth_zero", e.depth_zero, got.depth_zero);
      if (got.frame_done !== e.frame_done) report("frame_done", e.frame_done, got.frame_done);
      if (got.frame_sum !== e.frame_sum) report("frame_sum", e.frame_sum, got.frame_sum);
      if (got.frame_average !== e.frame_average)
        report("frame_average", e.frame_average, got.frame_average);
      if (got.total_error !== e.total_error) report("total_error", e.total_error, got.total_error);
      if (got.frames_seen !== e.frames_seen) report("frames_seen", e.frames_seen, got.frames_seen);
    endfunction
  endclass

  logic clk, rst, cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;
  rea_stream_if #(in_item_t) in_ch (clk);
  rea_stream_if #(out_item_t) out_ch (clk);

  reprojection_error_accumulator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  error_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int stall_hold = 0;
  int stall_mode = 0;
  int mode_left = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stall pattern: modes switch after a randomly drawn span
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 600);
      end
      mode_left--;
      if (stall_hold > 0) stall_hold--;
      else begin
        case (stall_mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= $urandom_range(0, 1);
          end
          2: begin
            out_ch.ready <= ~out_ch.ready;
            stall_hold = $urandom_range(0, 40);
          end
          default: begin
            out_ch.ready <= ($urandom_range(0, 7) != 0);
            stall_hold = $urandom_range(0, 3);
          end
        endcase
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.compare_result(out_ch.payload);

  task automatic send_point(in_item_t it);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end else @(negedge clk);
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_point(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // camera writes go in only once the block is idle; indices past five are written too
  task automatic load_camera(logic [63:0] regs[8]);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int i = IDX_00_01; i <= IDX_UNUSED_HI; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= regs[i];
      sb.set_reg(3'(i), regs[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pack_q(longint lo, longint hi);
    return {32'(hi), 32'(lo)};
  endfunction

  function automatic void pinhole(output logic [63:0] regs[8], input bit jitter);
    longint f, cx, cy;
    f = jitter ? longint'($urandom_range(50, 3000)) <<< 16 | $urandom_range(0, 65535) : ONE_Q;
    cx = jitter ? longint'($urandom_range(0, 1000)) <<< 16 : 0;
    cy = jitter ? longint'($urandom_range(0, 800)) <<< 16 : 0;
    regs[0] = pack_q(f, jitter ? $signed($urandom_range(0, 8191)) - 4096 : 0);
    regs[1] = pack_q(cx, jitter ? longint'($signed($urandom_range(0, 20))) - 10 <<< 16 : 0);
    regs[2] = pack_q(0, f);
    regs[3] = pack_q(cy, 0);
    regs[4] = pack_q(jitter ? $signed($urandom_range(0, 255)) - 128 : 0,
                     jitter ? $signed($urandom_range(0, 255)) - 128 : 0);
    regs[5] = pack_q(ONE_Q, jitter ? longint'($urandom_range(0, 3)) <<< 16 : 0);
    regs[6] = {$urandom, $urandom};
    regs[7] = {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: return w;
      1: return 32'($signed(w) >>> $urandom_range(8, 30));
      2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed(w[23:0]));
    endcase
  endfunction

  function automatic in_item_t make_point(int kind);
    in_item_t it;
    longint   p[3];
    it.last_in_frame = ($urandom_range(0, 11) == 0);
    case (kind)
      0: begin
        it.point_x = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        it.point_y = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        it.point_z = $urandom_range(1 << 14, 50 << 16);
        it.point_w = ($urandom_range(0, 3) == 0) ? $urandom : 32'(ONE_Q);
        it.obs_u = '0;
        it.obs_v = '0;
        sb.project(it, p);
        if (p[2] != 0) begin
          it.obs_u = 32'(sb.div_fx(p[0], p[2]) + $signed($urandom_range(0, 1 << 21)) - (1 << 20));
          it.obs_v = 32'(sb.div_fx(p[1], p[2]) + $signed($urandom_range(0, 1 << 21)) - (1 << 20));
        end
      end
      1: begin
        it.point_x = '0;
        it.point_y = '0;
        it.point_z = '0;
        it.point_w = '0;
        it.obs_u = $urandom;
        it.obs_v = $urandom;
      end
      default: begin
        it.point_x = rand_word();
        it.point_y = rand_word();
        it.point_z = rand_word();
        it.point_w = rand_word();
        it.obs_u = rand_word();
        it.obs_v = rand_word();
        it.last_in_frame = $urandom_range(0, 1);
      end
    endcase
    return it;
  endfunction

  function automatic in_item_t pt(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic [31:0] w, logic [31:0] u, logic [31:0] v, logic l);
    in_item_t it;
    it.point_x = x; it.point_y = y; it.point_z = z; it.point_w = w;
    it.obs_u = u; it.obs_v = v; it.last_in_frame = l;
    return it;
  endfunction

  initial begin
    logic [63:0] regs[8];
    int          kind;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all-zero camera after reset: every point has zero depth
    send_point(pt('1, 32'h7fffffff, 32'h80000000, 1, 32'h7fffffff, 32'h80000000, 1'b0));
    send_point(pt(0, 0, 0, 0, 0, 0, 1'b1));

    pinhole(regs, 0);
    load_camera(regs);
    send_point(pt(0, 0, 32'(ONE_Q), 0, 0, 0, 1'b0));
    send_point(pt(3 << 16, -(5 << 16), 2 << 16, 0, 32'h80000000, 32'h7fffffff, 1'b0));
    send_point(pt(0, 0, 32'(ONE_Q), 0, 32'h80000000, 32'h80000000, 1'b0));
    send_point(pt(0, 0, 32'(ONE_Q), 0, 32'h7fffffff, 32'h7fffffff, 1'b1));
    send_point(pt(32'h7fffffff, 32'h80000000, 1, 0, 0, 0, 1'b0));
    send_point(pt(-(7 << 16), 9 << 16, -(3 << 16), 0, 1 << 16, -(2 << 16), 1'b0));
    send_point(pt(5, 5, 0, 32'h7fffffff, 5, 5, 1'b0));
    send_point(pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 1'b0));
    send_point(pt(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, '1, '1, 1'b1));
    send_point(pt(1, 1, 1, 1, 1, 1, 1'b1));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: pinhole(regs, 1);
        1: foreach (regs[i]) regs[i] = {$urandom, $urandom};
        2: begin
          foreach (regs[i]) regs[i] = {32'h7fffffff, 32'h80000000};
          if (ph > 4) foreach (regs[i]) regs[i] = '1;
        end
        default: begin
          pinhole(regs, 1);
          regs[$urandom_range(0, 5)] = {$urandom, $urandom};
        end
      endcase
      load_camera(regs);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 9);
        kind = (kind < 7) ? 0 : (kind == 7) ? 1 : 2;
        send_point(make_point(kind));
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.expected_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

@@ reprojection_error_accumulator_top.f @@
hdl/rea_pkg.sv
hdl/rea_stream_if.sv
hdl/rea_ctrl.sv
hdl/rea_datapath.sv
hdl/reprojection_error_accumulator_top.sv
bench/tb_reprojection_error_accumulator_top.sv
